// ----- design/dltt_pkg.sv -----
// ----------------------------------------------------------------------------
// dltt_pkg
// shared types, codes and defaults for the delta list task timer
// ----------------------------------------------------------------------------
package dltt_pkg;

  localparam int SLOTS_DEF      = 16;
  localparam int DELAY_BITS_DEF = 16;
  localparam int MAX_FIRE       = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LINK_WALK,
    S_LINK_DONE,
    S_REM_WALK,
    S_REM_DONE,
    S_TICK_CHK,
    S_TICK_POP,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap_in;
    logic add_start;
    logic rem_start;
    logic tick_dec;
    logic link_step;
    logic link_commit;
    logic rem_step;
    logic rem_commit;
    logic tick_pop;
    logic res_load;
    logic res_full;
    logic res_empty;
    logic res_fired;
    logic res_last;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       rem_bad;
    logic       link_stop;
    logic       rem_stop;
    logic       head_due;
    logic       pop_periodic;
    logic       emit_any;
    logic       emit_cap;
  } stat_t;

endpackage

// ----- design/dltt_datapath.sv -----
// ----------------------------------------------------------------------------
// dltt_datapath
// slot pool, list head, walk pointers and result register
// ----------------------------------------------------------------------------
module dltt_datapath #(
  parameter int SLOTS      = dltt_pkg::SLOTS_DEF,
  parameter int DELAY_BITS = dltt_pkg::DELAY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dltt_pkg::ctrl_t     ctrl,
  output dltt_pkg::stat_t     stat,
  input  logic [1:0]          in_op,
  input  logic [15:0]         in_delay_ticks,
  input  logic [15:0]         in_period_ticks,
  input  logic [7:0]          in_task_id,
  input  logic [3:0]          in_slot_sel,
  output logic [1:0]          res_status,
  output logic [3:0]          res_slot,
  output logic                res_fired,
  output logic [7:0]          res_task,
  output logic                res_last
);

  localparam int SW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(dltt_pkg::MAX_FIRE + 1);
  localparam logic [SW-1:0] NONE = SW'(SLOTS);
  localparam logic [DELAY_BITS-1:0] DMAX = '1;

  logic [SW-1:0]         link_r  [SLOTS];
  logic [DELAY_BITS-1:0] delta_r [SLOTS];
  logic [DELAY_BITS-1:0] per_r   [SLOTS];
  logic [7:0]            task_r  [SLOTS];
  logic [SLOTS-1:0]      used_r;
  logic [SW-1:0]         head_r;

  logic [1:0]            op_r;
  logic [3:0]            sel_r;
  logic [DELAY_BITS-1:0] dly_r, pin_r;
  logic [7:0]            tin_r, ptask_r;
  logic [SW-1:0]         slot_r, prev_r, cur_r;
  logic [CW-1:0]         emit_r;

  logic [IW-1:0]         slot_i, prev_i, cur_i, head_i, sel_i, nxt_i, free_i;
  logic [SW-1:0]         free_slot, sel_w, nxt_w;
  logic [DELAY_BITS-1:0] cur_delta;
  logic [DELAY_BITS:0]   rem_sum;
  logic                  sel_ok;
  logic [DELAY_BITS-1:0] din_dly, din_per;

  assign slot_i    = slot_r[IW-1:0];
  assign prev_i    = prev_r[IW-1:0];
  assign cur_i     = cur_r[IW-1:0];
  assign head_i    = head_r[IW-1:0];
  assign sel_i     = IW'(sel_r);
  assign sel_w     = SW'(sel_r);
  assign free_i    = free_slot[IW-1:0];
  assign nxt_w     = link_r[sel_i];
  assign nxt_i     = nxt_w[IW-1:0];
  assign cur_delta = delta_r[cur_i];

  always_comb begin
    if (DELAY_BITS >= 16) begin
      din_dly = DELAY_BITS'(in_delay_ticks);
      din_per = DELAY_BITS'(in_period_ticks);
    end else begin
      din_dly = (in_delay_ticks > 16'(DMAX)) ? DMAX : DELAY_BITS'(in_delay_ticks);
      din_per = (in_period_ticks > 16'(DMAX)) ? DMAX : DELAY_BITS'(in_period_ticks);
    end
  end

  // lowest free slot, NONE when the pool is full
  always_comb begin
    free_slot = NONE;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) free_slot = SW'(i);
    end
  end

  assign sel_ok  = (32'(sel_r) < 32'(SLOTS)) && used_r[sel_i];
  assign rem_sum = {1'b0, delta_r[nxt_i]} + {1'b0, delta_r[sel_i]};

  always_comb begin
    stat.op           = op_r;
    stat.full         = (free_slot == NONE);
    stat.rem_bad      = !sel_ok;
    stat.link_stop    = (cur_r == NONE) || (dly_r <= cur_delta);
    stat.rem_stop     = (cur_r == NONE) || (cur_r == sel_w);
    stat.head_due     = (head_r != NONE) && (delta_r[head_i] == '0);
    stat.pop_periodic = (per_r[head_i] != '0);
    stat.emit_any     = (emit_r != '0);
    stat.emit_cap     = (emit_r == CW'(dltt_pkg::MAX_FIRE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      head_r <= NONE;
      for (int i = 0; i < SLOTS; i++) begin
        link_r[i]  <= NONE;
        delta_r[i] <= '0;
        per_r[i]   <= '0;
        task_r[i]  <= '0;
      end
      op_r       <= '0;
      sel_r      <= '0;
      dly_r      <= '0;
      pin_r      <= '0;
      tin_r      <= '0;
      ptask_r    <= '0;
      slot_r     <= '0;
      prev_r     <= NONE;
      cur_r      <= NONE;
      emit_r     <= '0;
      res_status <= '0;
      res_slot   <= '0;
      res_fired  <= 1'b0;
      res_task   <= '0;
      res_last   <= 1'b0;
    end else begin
      if (ctrl.cap_in) begin
        op_r   <= in_op;
        sel_r  <= in_slot_sel;
        dly_r  <= (din_dly == '0) ? DELAY_BITS'(1) : din_dly;
        pin_r  <= din_per;
        tin_r  <= in_task_id;
        emit_r <= '0;
      end
      if (ctrl.add_start) begin
        slot_r         <= free_slot;
        used_r[free_i] <= 1'b1;
        per_r[free_i]  <= pin_r;
        task_r[free_i] <= tin_r;
        prev_r         <= NONE;
        cur_r          <= head_r;
      end
      if (ctrl.rem_start) begin
        prev_r <= NONE;
        cur_r  <= head_r;
      end
      if (ctrl.link_step) begin
        dly_r  <= dly_r - cur_delta;
        prev_r <= cur_r;
        cur_r  <= link_r[cur_i];
      end
      if (ctrl.rem_step) begin
        prev_r <= cur_r;
        cur_r  <= link_r[cur_i];
      end
      if (ctrl.link_commit) begin
        delta_r[slot_i] <= dly_r;
        link_r[slot_i]  <= cur_r;
        if (cur_r != NONE) delta_r[cur_i] <= cur_delta - dly_r;
        if (prev_r == NONE) head_r <= slot_r;
        else link_r[prev_i] <= slot_r;
      end
      if (ctrl.rem_commit) begin
        if (cur_r == sel_w) begin
          if (prev_r == NONE) head_r <= nxt_w;
          else link_r[prev_i] <= nxt_w;
          if (nxt_w != NONE)
            delta_r[nxt_i] <= rem_sum[DELAY_BITS] ? DMAX : rem_sum[DELAY_BITS-1:0];
        end
        used_r[sel_i]  <= 1'b0;
        link_r[sel_i]  <= NONE;
        delta_r[sel_i] <= '0;
        per_r[sel_i]   <= '0;
        task_r[sel_i]  <= '0;
      end
      if (ctrl.tick_dec && head_r != NONE && delta_r[head_i] != '0)
        delta_r[head_i] <= delta_r[head_i] - DELAY_BITS'(1);
      if (ctrl.tick_pop) begin
        slot_r         <= head_r;
        ptask_r        <= task_r[head_i];
        head_r         <= link_r[head_i];
        link_r[head_i] <= NONE;
        emit_r         <= emit_r + CW'(1);
        // relink walk starts from the new head
        prev_r         <= NONE;
        cur_r          <= link_r[head_i];
        dly_r          <= per_r[head_i];
        if (per_r[head_i] == '0) begin
          used_r[head_i]  <= 1'b0;
          delta_r[head_i] <= '0;
          task_r[head_i]  <= '0;
        end
      end
      if (ctrl.res_load) begin
        res_last  <= ctrl.res_last;
        res_fired <= ctrl.res_fired;
        res_task  <= ctrl.res_fired ? ptask_r : 8'd0;
        if (ctrl.res_full) res_status <= dltt_pkg::ST_FULL;
        else if (ctrl.res_empty) res_status <= dltt_pkg::ST_EMPTY;
        else res_status <= dltt_pkg::ST_OK;
        if (ctrl.res_full) res_slot <= 4'd0;
        else if (ctrl.res_fired || op_r == dltt_pkg::OP_ADD) res_slot <= 4'(slot_r);
        else if (op_r == dltt_pkg::OP_REMOVE) res_slot <= sel_r;
        else res_slot <= 4'd0;
      end
    end
  end

endmodule

// ----- design/dltt_ctrl.sv -----
// ----------------------------------------------------------------------------
// dltt_ctrl
// sequencer for add, remove and tick transactions
// ----------------------------------------------------------------------------
module dltt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  dltt_pkg::stat_t stat,
  output dltt_pkg::ctrl_t ctrl
);

  dltt_pkg::state_t state_r, state_nxt;
  logic valid_r, valid_nxt;
  logic take, free_out, more;

  assign take     = (state_r == dltt_pkg::S_IDLE) && in_valid;
  assign free_out = !valid_r || !out_stall;
  // another task is due in this tick
  assign more     = stat.head_due && !stat.emit_cap;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dltt_pkg::S_IDLE: if (in_valid) state_nxt = dltt_pkg::S_DISPATCH;
      dltt_pkg::S_DISPATCH: begin
        case (stat.op)
          dltt_pkg::OP_ADD: state_nxt = stat.full ? dltt_pkg::S_EMIT :
                                        dltt_pkg::S_LINK_WALK;
          dltt_pkg::OP_REMOVE: state_nxt = stat.rem_bad ? dltt_pkg::S_EMIT :
                                           dltt_pkg::S_REM_WALK;
          dltt_pkg::OP_TICK: state_nxt = dltt_pkg::S_TICK_CHK;
          default: state_nxt = dltt_pkg::S_EMIT;
        endcase
      end
      dltt_pkg::S_LINK_WALK: if (stat.link_stop) state_nxt = dltt_pkg::S_LINK_DONE;
      dltt_pkg::S_LINK_DONE: begin
        if (stat.op == dltt_pkg::OP_TICK) state_nxt = dltt_pkg::S_TICK_CHK;
        else if (free_out) state_nxt = dltt_pkg::S_IDLE;
      end
      dltt_pkg::S_REM_WALK: if (stat.rem_stop) state_nxt = dltt_pkg::S_REM_DONE;
      dltt_pkg::S_REM_DONE: if (free_out) state_nxt = dltt_pkg::S_IDLE;
      dltt_pkg::S_TICK_CHK: begin
        if (!stat.emit_any) begin
          if (more) state_nxt = dltt_pkg::S_TICK_POP;
          else if (free_out) state_nxt = dltt_pkg::S_IDLE;
        end else if (free_out) begin
          state_nxt = more ? dltt_pkg::S_TICK_POP : dltt_pkg::S_IDLE;
        end
      end
      dltt_pkg::S_TICK_POP: state_nxt = stat.pop_periodic ? dltt_pkg::S_LINK_WALK :
                                        dltt_pkg::S_TICK_CHK;
      dltt_pkg::S_EMIT: if (free_out) state_nxt = dltt_pkg::S_IDLE;
      default: state_nxt = dltt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.cap_in = take;
    case (state_r)
      dltt_pkg::S_DISPATCH: begin
        if (stat.op == dltt_pkg::OP_ADD) ctrl.add_start = !stat.full;
        else if (stat.op == dltt_pkg::OP_REMOVE) ctrl.rem_start = !stat.rem_bad;
        else if (stat.op == dltt_pkg::OP_TICK) ctrl.tick_dec = 1'b1;
      end
      dltt_pkg::S_LINK_WALK: ctrl.link_step = !stat.link_stop;
      dltt_pkg::S_LINK_DONE: begin
        if (stat.op == dltt_pkg::OP_TICK) ctrl.link_commit = 1'b1;
        else if (free_out) begin
          ctrl.link_commit = 1'b1;
          ctrl.res_load    = 1'b1;
          ctrl.res_last    = 1'b1;
        end
      end
      dltt_pkg::S_REM_WALK: ctrl.rem_step = !stat.rem_stop;
      dltt_pkg::S_REM_DONE: begin
        if (free_out) begin
          ctrl.rem_commit = 1'b1;
          ctrl.res_load   = 1'b1;
          ctrl.res_last   = 1'b1;
        end
      end
      dltt_pkg::S_TICK_CHK: begin
        // a popped task is shown once we know whether another follows
        if (!stat.emit_any) begin
          if (!more && free_out) begin
            ctrl.res_load = 1'b1;
            ctrl.res_last = 1'b1;
          end
        end else if (free_out) begin
          ctrl.res_load  = 1'b1;
          ctrl.res_fired = 1'b1;
          ctrl.res_last  = !more;
        end
      end
      dltt_pkg::S_TICK_POP: ctrl.tick_pop = 1'b1;
      dltt_pkg::S_EMIT: begin
        if (free_out) begin
          ctrl.res_load  = 1'b1;
          ctrl.res_last  = 1'b1;
          ctrl.res_full  = (stat.op == dltt_pkg::OP_ADD);
          ctrl.res_empty = (stat.op == dltt_pkg::OP_REMOVE);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (ctrl.res_load) valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dltt_pkg::S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign in_stall  = (state_r != dltt_pkg::S_IDLE);
  assign out_valid = valid_r;

endmodule

// ----- design/delta_list_task_timer.sv -----
// ----------------------------------------------------------------------------
// delta_list_task_timer
// task timer keeping a pool of slots in a list sorted by relative delay
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   op, delay, period, task id, slot
// out_      output     out_valid / out_stall status, slot, fired, task, last
//
// an add or remove walks the list over at most 15 slots before it commits;
// one transaction at a time
// a tick pops each due task, up to MAX_FIRE of them, and a periodic one is
// relinked by a walk like that of an add
// reset is synchronous; the whole pool clears in the reset cycle
// a stalled result holds the sequencer in the state that loads the next result
// ----------------------------------------------------------------------------
module delta_list_task_timer #(
  parameter int SLOTS      = dltt_pkg::SLOTS_DEF,
  parameter int DELAY_BITS = dltt_pkg::DELAY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_delay_ticks,
  input  logic [15:0] in_period_ticks,
  input  logic [7:0]  in_task_id,
  input  logic [3:0]  in_slot_sel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot_out,
  output logic        out_fired,
  output logic [7:0]  out_fired_task,
  output logic        out_last
);

  dltt_pkg::ctrl_t ctrl;
  dltt_pkg::stat_t stat;

  dltt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .ctrl(ctrl)
  );

  dltt_datapath #(.SLOTS(SLOTS), .DELAY_BITS(DELAY_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
    .in_op(in_op), .in_delay_ticks(in_delay_ticks),
    .in_period_ticks(in_period_ticks), .in_task_id(in_task_id),
    .in_slot_sel(in_slot_sel),
    .res_status(out_status), .res_slot(out_slot_out), .res_fired(out_fired),
    .res_task(out_fired_task), .res_last(out_last)
  );

  // a result that the sink stalls must hold
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_slot_out) && $stable(out_fired) && $stable(out_fired_task) &&
    $stable(out_last))
    else $error("stalled result changed");

  // a new transaction is never taken while one is in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // only fired results can be followed by more results of the same transaction
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fired |-> out_last)
    else $error("non-fired result without last");

endmodule

// ----- test/delta_list_task_timer_tb.sv -----
// ----------------------------------------------------------------------------
// delta_list_task_timer_tb
// checks the task timer against a slot-pool model of the delta list
// ----------------------------------------------------------------------------
// each transaction into the block is run through a local model of the pool
// and its results are queued; a monitor pops one result per accepted output
// transaction and compares every field
// ----------------------------------------------------------------------------
module delta_list_task_timer_tb;

  localparam int NSLOT     = 16;
  localparam int NONE      = 16;
  localparam int MAX_FIRE  = 16;
  localparam int CYCLE_CAP = 2000000;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot;
    logic       fired;
    logic [7:0] task_id;
    logic       last;
  } timer_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = dltt_pkg::OP_TICK;
  logic [15:0] in_delay_ticks = '0;
  logic [15:0] in_period_ticks = '0;
  logic [7:0]  in_task_id = '0;
  logic [3:0]  in_slot_sel = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_slot_out;
  logic        out_fired;
  logic [7:0]  out_fired_task;
  logic        out_last;

  // model of the pool
  int          nxt_of [NSLOT];
  logic [15:0] rel_delta [NSLOT];
  logic [15:0] period_of [NSLOT];
  logic [7:0]  id_of [NSLOT];
  bit          busy [NSLOT];
  int          head_slot;

  timer_res_t  pending_res [$];
  int          errors = 0;
  int          cycles = 0;
  bit          idle_on = 1'b1;

  delta_list_task_timer i_dut (.*);

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls in random bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    timer_res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_slot_out, out_fired, out_fired_task, out_last};
      if (pending_res.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
      end else begin
        want = pending_res.pop_front();
        if (got.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          errors++;
        end
        if (got.slot !== want.slot) begin
          $error("slot_out expected %0d actual %0d", want.slot, got.slot);
          errors++;
        end
        if (got.fired !== want.fired) begin
          $error("fired expected %0d actual %0d", want.fired, got.fired);
          errors++;
        end
        if (got.task_id !== want.task_id) begin
          $error("fired_task expected %0d actual %0d", want.task_id, got.task_id);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, got.last);
          errors++;
        end
      end
    end
  end

  function automatic void pool_clear();
    for (int i = 0; i < NSLOT; i++) begin
      nxt_of[i] = NONE;
      rel_delta[i] = '0;
      period_of[i] = '0;
      id_of[i] = '0;
      busy[i] = 1'b0;
    end
    head_slot = NONE;
  endfunction

  // insert slot at absolute delay dly; ties go in front
  function automatic void sorted_link(int s, logic [15:0] dly);
    int prv, cur, g;
    prv = NONE;
    cur = head_slot;
    g = 0;
    while (cur < NONE && dly > rel_delta[cur] && g < NSLOT) begin
      dly = dly - rel_delta[cur];
      prv = cur;
      cur = nxt_of[cur];
      g++;
    end
    rel_delta[s] = dly;
    nxt_of[s] = cur;
    if (cur < NONE) rel_delta[cur] = rel_delta[cur] - dly;
    if (prv == NONE) head_slot = s;
    else nxt_of[prv] = s;
  endfunction

  function automatic void release_slot(int s);
    busy[s] = 1'b0;
    nxt_of[s] = NONE;
    rel_delta[s] = '0;
    period_of[s] = '0;
    id_of[s] = '0;
  endfunction

  function automatic void predict_timer(logic [1:0] op, logic [15:0] dly,
                                        logic [15:0] per, logic [7:0] tid,
                                        logic [3:0] sel);
    int s, prv, cur, g, n, nx;
    logic [16:0] sum;
    if (op == dltt_pkg::OP_ADD) begin
      s = 0;
      while (s < NSLOT && busy[s]) s++;
      if (s >= NSLOT) begin
        pending_res.push_back('{dltt_pkg::ST_FULL, 4'd0, 1'b0, 8'd0, 1'b1});
        return;
      end
      if (dly == 0) dly = 16'd1;
      busy[s] = 1'b1;
      period_of[s] = per;
      id_of[s] = tid;
      sorted_link(s, dly);
      pending_res.push_back('{dltt_pkg::ST_OK, 4'(s), 1'b0, 8'd0, 1'b1});
    end else if (op == dltt_pkg::OP_REMOVE) begin
      if (!busy[sel]) begin
        pending_res.push_back('{dltt_pkg::ST_EMPTY, sel, 1'b0, 8'd0, 1'b1});
        return;
      end
      prv = NONE;
      cur = head_slot;
      g = 0;
      while (cur < NONE && cur != sel && g < NSLOT) begin
        prv = cur;
        cur = nxt_of[cur];
        g++;
      end
      if (cur == sel) begin
        nx = nxt_of[sel];
        if (prv == NONE) head_slot = nx;
        else nxt_of[prv] = nx;
        if (nx < NONE) begin
          sum = rel_delta[nx] + rel_delta[sel];
          rel_delta[nx] = sum[16] ? 16'hffff : sum[15:0];
        end
      end
      release_slot(sel);
      pending_res.push_back('{dltt_pkg::ST_OK, sel, 1'b0, 8'd0, 1'b1});
    end else if (op == dltt_pkg::OP_TICK) begin
      n = 0;
      if (head_slot < NONE && rel_delta[head_slot] > 0)
        rel_delta[head_slot] = rel_delta[head_slot] - 1;
      while (n < MAX_FIRE && head_slot < NONE && rel_delta[head_slot] == 0) begin
        s = head_slot;
        tid = id_of[s];
        head_slot = nxt_of[s];
        nxt_of[s] = NONE;
        if (period_of[s] != 0) sorted_link(s, period_of[s]);
        else release_slot(s);
        pending_res.push_back('{dltt_pkg::ST_OK, 4'(s), 1'b1, tid, 1'b0});
        n++;
      end
      if (n == 0) pending_res.push_back('{dltt_pkg::ST_OK, 4'd0, 1'b0, 8'd0, 1'b1});
      else pending_res[$].last = 1'b1;
    end else begin
      // unused op code
      pending_res.push_back('{dltt_pkg::ST_OK, 4'd0, 1'b0, 8'd0, 1'b1});
    end
  endfunction

  // send one transaction, with an optional random gap in front
  task automatic send_cmd(logic [1:0] op, logic [15:0] dly = 0,
                          logic [15:0] per = 0, logic [7:0] tid = 0,
                          logic [3:0] sel = 0);
    int n;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 13);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_delay_ticks <= dly;
    in_period_ticks <= per;
    in_task_id <= tid;
    in_slot_sel <= sel;
    predict_timer(op, dly, per, tid, sel);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // the block holds in_stall while it works on a taken transaction
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (pending_res.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic test_directed();
    send_cmd(dltt_pkg::OP_TICK);                                // tick on empty list
    send_cmd(dltt_pkg::OP_REMOVE, 0, 0, 0, 4'd15);              // remove free slot
    send_cmd(dltt_pkg::OP_ADD, 16'd0, 16'd0, 8'hff);            // zero delay
    send_cmd(dltt_pkg::OP_ADD, 16'hffff, 16'hffff, 8'h00);      // widest delay
    send_cmd(dltt_pkg::OP_ADD, 16'd1, 16'd3, 8'h5a);            // equal due time
    send_cmd(dltt_pkg::OP_ADD, 16'd2, 16'd0, 8'ha5);
    send_cmd(dltt_pkg::OP_TICK);
    send_cmd(dltt_pkg::OP_TICK);
    send_cmd(dltt_pkg::OP_REMOVE, 0, 0, 0, 4'd1);               // remove tail of list
    send_cmd(dltt_pkg::OP_UNUSED, 16'hffff, 16'hffff, 8'hff, 4'hf);
    send_cmd(dltt_pkg::OP_TICK);
    wait_drain();
  endtask

  // fill the pool, overflow it, fire all sixteen at once
  task automatic test_pool_full();
    for (int i = 0; i < NSLOT; i++) begin
      if (!busy[i]) send_cmd(dltt_pkg::OP_ADD, 16'd1, 16'd1, 8'(i));
    end
    send_cmd(dltt_pkg::OP_ADD, 16'd5, 16'd0, 8'h77);
    send_cmd(dltt_pkg::OP_TICK);
    send_cmd(dltt_pkg::OP_TICK);
    for (int i = 0; i < NSLOT; i++) send_cmd(dltt_pkg::OP_REMOVE, 0, 0, 0, 4'(i));
    wait_drain();
  endtask

  task automatic test_random(int count);
    int k;
    logic [15:0] d, p;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      d = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      p = ($urandom_range(0, 2) == 0) ? 16'd0 :
          ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8));
      if (k < 35) send_cmd(dltt_pkg::OP_ADD, d, p, 8'($urandom));
      else if (k < 50) send_cmd(dltt_pkg::OP_REMOVE, 16'($urandom), 16'($urandom),
                                8'($urandom), 4'($urandom));
      else if (k < 97) send_cmd(dltt_pkg::OP_TICK, 16'($urandom), 16'($urandom));
      else send_cmd(dltt_pkg::OP_UNUSED, 16'($urandom), 16'($urandom), 8'($urandom),
                    4'($urandom));
      if (i == count / 2) wait_drain();   // sender holds off until drained
    end
  endtask

  initial begin
    pool_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pool_full();
    test_random(260);
    idle_on = 1'b0;
    test_random(70);
    wait_drain();
    if (errors == 0 && pending_res.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
